>>> rtl/ebmw_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and a helper function for the ext2 block map walker.
package ebmw_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 4;
    localparam int WORD_W   = 32;
    localparam int KIND_W   = 2;
    localparam int WIDX_W   = 14;
    localparam int LEVEL_W  = 2;
    localparam int LBS_W    = 3;
    localparam int BOUND_W  = 44;
    localparam int SHIFT_W  = 4;
    localparam int AMT_W    = 5;

    // Inode pointer layout
    localparam int POINTER_SLOTS = 15;
    localparam int DIRECT_SLOTS  = 12;

    // Block size register limits: pointers per block is 1 << (lbs + 8)
    localparam logic [LBS_W-1:0]   LBS_MAX    = 3'd6;
    localparam logic [SHIFT_W-1:0] SHIFT_BASE = 4'd8;

    // APB register map
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Input op codes
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_MAP  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESP = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MAPPED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RANGE  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] file_block;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] block_number;
        logic [WIDX_W-1:0] word_index;
    } out_item_t;

    // Walk result toward the output register
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } walk_result_t;

    // Pointer table write port
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } ptr_wr_t;

    // Pointers-per-block shift, register saturated at six
    function automatic logic [SHIFT_W-1:0] ptr_shift(input logic [LBS_W-1:0] lbs);
        logic [LBS_W-1:0] l;
        l = (lbs > LBS_MAX) ? LBS_MAX : lbs;
        return SHIFT_BASE + {1'b0, l};
    endfunction

endpackage

>>> rtl/ebmw_apb_regs.sv
`timescale 1ns / 1ps
// APB configuration register: block size exponent.
module ebmw_apb_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ebmw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ebmw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ebmw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [ebmw_pkg::LBS_W-1:0]       log_block_size
);
    import ebmw_pkg::*;

    logic [LBS_W-1:0] lbs_reg;
    logic             reg0_sel;

    // Only register 0 exists; word address is paddr[2]
    assign reg0_sel = (paddr[APB_ADDR_W-1] == 1'b0);
    assign pready   = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lbs_reg <= '0;
        end else if (psel && penable && pwrite && reg0_sel) begin
            lbs_reg <= pwdata[LBS_W-1:0];
        end
    end

    // Read back the raw register value
    assign prdata = reg0_sel ? {{(APB_DATA_W-LBS_W){1'b0}}, lbs_reg} : '0;

    assign log_block_size = lbs_reg;

endmodule

>>> rtl/ebmw_ptr_table.sv
`timescale 1ns / 1ps
// Inode block pointer table: one write port, one read port.
module ebmw_ptr_table (
    input  logic                           aclk,
    input  ebmw_pkg::ptr_wr_t              wr,
    input  logic [ebmw_pkg::SLOT_W-1:0]    raddr,
    output logic [ebmw_pkg::WORD_W-1:0]    rdata
);
    import ebmw_pkg::*;

    logic [WORD_W-1:0] slot_reg [POINTER_SLOTS];

    // Contents are undefined until loaded, so no reset
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            slot_reg[wr.addr] <= wr.data;
        end
    end

    assign rdata = slot_reg[raddr];

endmodule

>>> rtl/ebmw_walk.sv
`timescale 1ns / 1ps
// Walk state and per-item decode: direct map, level select and word index.
module ebmw_walk (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           apply,
    input  ebmw_pkg::in_item_t             item,
    input  logic [ebmw_pkg::LBS_W-1:0]     log_block_size,
    input  logic [ebmw_pkg::WORD_W-1:0]    ptr_rdata,
    output logic [ebmw_pkg::SLOT_W-1:0]    ptr_raddr,
    output ebmw_pkg::ptr_wr_t              ptr_wr,
    output ebmw_pkg::walk_result_t         result
);
    import ebmw_pkg::*;

    logic                busy_reg,   busy_next;
    logic [LEVEL_W-1:0]  level_reg,  level_next;
    logic [WORD_W-1:0]   offset_reg, offset_next;

    logic [SHIFT_W-1:0]  sh;
    logic [BOUND_W-1:0]  x1, x2, x3;
    logic [BOUND_W-1:0]  bound1, bound2, bound3;
    logic [BOUND_W-1:0]  fb_wide;
    logic                is_direct;
    logic                in_l0, in_l1, in_l2;
    logic [LEVEL_W-1:0]  map_level;
    logic [BOUND_W-1:0]  map_base;
    logic [WORD_W-1:0]   map_offset;
    logic [LEVEL_W-1:0]  resp_level;

    // Word index of a given level within a tree offset
    function automatic logic [WIDX_W-1:0] word_index(
        input logic [WORD_W-1:0]  off,
        input logic [SHIFT_W-1:0] s,
        input logic [LEVEL_W-1:0] lvl
    );
        logic [AMT_W-1:0]  amt;
        logic [WIDX_W:0]   mask;
        logic [WORD_W-1:0] shifted;
        case (lvl)
            2'd0:    amt = '0;
            2'd1:    amt = {1'b0, s};
            default: amt = {s, 1'b0};
        endcase
        mask    = (({{WIDX_W{1'b0}}, 1'b1}) << s) - 1'b1;
        shifted = off >> amt;
        return shifted[WIDX_W-1:0] & mask[WIDX_W-1:0];
    endfunction

    // Tree bounds; these only follow the config register
    assign sh      = ptr_shift(log_block_size);
    assign x1      = {{(BOUND_W-1){1'b0}}, 1'b1} << sh;
    assign x2      = {{(BOUND_W-1){1'b0}}, 1'b1} << {sh, 1'b0};
    assign x3      = {{(BOUND_W-1){1'b0}}, 1'b1} << ({2'b00, sh} + {1'b0, sh, 1'b0});
    assign bound1  = BOUND_W'(DIRECT_SLOTS) + x1;
    assign bound2  = bound1 + x2;
    assign bound3  = bound2 + x3;

    // Range compares against the file block
    assign fb_wide   = {{(BOUND_W-WORD_W){1'b0}}, item.file_block};
    assign is_direct = (item.file_block < WORD_W'(DIRECT_SLOTS));
    assign in_l0     = (fb_wide < bound1);
    assign in_l1     = (fb_wide < bound2);
    assign in_l2     = (fb_wide < bound3);

    always_comb begin
        if (in_l0) begin
            map_level = 2'd0;
            map_base  = BOUND_W'(DIRECT_SLOTS);
        end else if (in_l1) begin
            map_level = 2'd1;
            map_base  = bound1;
        end else begin
            map_level = 2'd2;
            map_base  = bound2;
        end
    end

    assign map_offset = item.file_block - map_base[WORD_W-1:0];
    assign resp_level = level_reg - 1'b1;

    // Direct slot or indirect root pointer
    assign ptr_raddr = is_direct ? item.file_block[SLOT_W-1:0]
                                 : SLOT_W'(DIRECT_SLOTS) + {2'b00, map_level};

    // Pointer loads are taken whether or not a walk is active
    assign ptr_wr.en   = apply && (item.op == OP_LOAD) && (item.slot < SLOT_W'(POINTER_SLOTS));
    assign ptr_wr.addr = item.slot;
    assign ptr_wr.data = item.value;

    // Per-item decode
    always_comb begin
        busy_next   = busy_reg;
        level_next  = level_reg;
        offset_next = offset_reg;
        result      = '0;
        case (item.op)
            OP_MAP: begin
                if (!busy_reg) begin
                    result.valid = 1'b1;
                    if (is_direct) begin
                        result.item.kind         = KIND_MAPPED;
                        result.item.block_number = ptr_rdata;
                    end else if (!in_l2) begin
                        result.item.kind = KIND_RANGE;
                    end else begin
                        busy_next                = 1'b1;
                        level_next               = map_level;
                        offset_next              = map_offset;
                        result.item.kind         = KIND_READ;
                        result.item.block_number = ptr_rdata;
                        result.item.word_index   = word_index(map_offset, sh, map_level);
                    end
                end
            end
            OP_RESP: begin
                if (busy_reg) begin
                    result.valid             = 1'b1;
                    result.item.block_number = item.value;
                    if (level_reg == 2'd0) begin
                        busy_next        = 1'b0;
                        offset_next      = '0;
                        result.item.kind = KIND_MAPPED;
                    end else begin
                        level_next             = resp_level;
                        result.item.kind       = KIND_READ;
                        result.item.word_index = word_index(offset_reg, sh, resp_level);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            level_reg  <= '0;
            offset_reg <= '0;
        end else if (apply) begin
            busy_reg   <= busy_next;
            level_reg  <= level_next;
            offset_reg <= offset_next;
        end
    end

endmodule

>>> rtl/ext2_indirect_block_map_walker.sv
`timescale 1ns / 1ps
// Top level of the ext2 indirect block map walker.
//
// Maps a file's logical block number to a disk block through the inode's
// fifteen block pointers. Items enter on the s_ channel: op 0 loads a
// pointer slot, op 1 asks for a mapping, op 2 returns a word read from an
// indirect block. Each item gives at most one result on the m_ channel:
// a word-read request (kind 0), the mapped block (kind 1) or an
// out-of-range error (kind 2). The caller answers each read request with
// an op 2 item; a walk takes one request per indirect level.
// The block size exponent is set through the APB register at address 0.
// Items pass through the input register, one pass of decode logic and the
// result register that drives m_valid. Throughput: one item per cycle while
// the receiver takes results, set by the single pass of decode logic.
// Reset clears the walk state and the block size register; pointer slots
// hold nothing defined until loaded. When the receiver stalls, the result
// register holds, one more item waits in the input register, and s_ready
// then drops until the result is taken.
module ext2_indirect_block_map_walker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ebmw_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ebmw_pkg::out_item_t              m_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ebmw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ebmw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ebmw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import ebmw_pkg::*;

    logic             in_valid_reg;
    in_item_t         in_data_reg;
    logic             out_valid_reg;
    out_item_t        out_data_reg;
    logic             advance;
    logic [LBS_W-1:0] log_block_size;
    logic [SLOT_W-1:0] ptr_raddr;
    logic [WORD_W-1:0] ptr_rdata;
    ptr_wr_t          ptr_wr;
    walk_result_t     result;

    ebmw_apb_regs u_regs (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .log_block_size (log_block_size)
    );

    ebmw_ptr_table u_ptrs (
        .aclk  (aclk),
        .wr    (ptr_wr),
        .raddr (ptr_raddr),
        .rdata (ptr_rdata)
    );

    ebmw_walk u_walk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .apply          (advance),
        .item           (in_data_reg),
        .log_block_size (log_block_size),
        .ptr_rdata      (ptr_rdata),
        .ptr_raddr      (ptr_raddr),
        .ptr_wr         (ptr_wr),
        .result         (result)
    );

    // The held item moves on when the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= result.valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            out_data_reg <= result.item;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // A stalled input item is neither lost nor overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("held input item changed while stalled");

    // A new result only comes from an item that was held in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without an input item");

    // Only read requests carry a word index; range errors carry no block
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind != KIND_READ) |-> (m_data.word_index == '0))
        else $error("word index set on a non-read result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == KIND_RANGE) |-> (m_data.block_number == '0))
        else $error("block number set on an out-of-range result");
`endif

endmodule

>>> verif/tb_ext2_indirect_block_map_walker.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ext2 indirect block map walker.
module tb_ext2_indirect_block_map_walker;
    import ebmw_pkg::*;

    localparam int CYCLE_LIMIT        = 400_000;
    localparam int DRAIN_CYCLES       = 8;
    localparam int HOLD_OFF_CYCLES    = 300;
    localparam int CFG_EVERY          = 100;
    localparam int REG_LOG_BLOCK_SIZE = 0;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Clock, reset and block ports
    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ext2_indirect_block_map_walker dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mapping state as the testbench tracks it
    logic [WORD_W-1:0]  ptr_slots [POINTER_SLOTS];
    logic [LEVEL_W-1:0] cur_level   = '0;
    logic [WORD_W-1:0]  cur_offset  = '0;
    bit                 walk_active = 1'b0;
    logic [LBS_W-1:0]   cfg_lbs     = '0;

    out_item_t expected_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int handled_items  = 0;
    int ignored_items  = 0;
    int checked        = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int kind_seen [3]  = '{0, 0, 0};

    // log2 of pointers per block; register saturates at six
    function automatic int unsigned ptrs_log2();
        return ((cfg_lbs > LBS_MAX) ? 6 : int'(cfg_lbs)) + 8;
    endfunction

    // Word-read request into blk for the current level of the walk
    function automatic out_item_t read_request(input logic [WORD_W-1:0] blk);
        out_item_t   r;
        int unsigned sh;
        logic [31:0] idx;
        sh  = ptrs_log2();
        idx = (cur_offset >> (sh * cur_level)) & ((32'd1 << sh) - 32'd1);
        r.kind         = KIND_READ;
        r.block_number = blk;
        r.word_index   = idx[WIDX_W-1:0];
        return r;
    endfunction

    // Advance the tracked state by one item; returns 1 when a result follows
    function automatic bit predict_mapping(input in_item_t it, output out_item_t res);
        longint unsigned x, b;
        int              lvl;
        res = '0;
        case (it.op)
            OP_LOAD: begin
                if (it.slot < POINTER_SLOTS)
                    ptr_slots[it.slot] = it.value;
                return 1'b0;
            end
            OP_MAP: begin
                if (walk_active)
                    return 1'b0;
                if (it.file_block < DIRECT_SLOTS) begin
                    res.kind         = KIND_MAPPED;
                    res.block_number = ptr_slots[it.file_block[SLOT_W-1:0]];
                    return 1'b1;
                end
                x = 64'd1 << ptrs_log2();
                b = {32'd0, it.file_block} - DIRECT_SLOTS;
                if (b < x) begin
                    lvl = 0;
                end else begin
                    b -= x;
                    if (b < x * x) begin
                        lvl = 1;
                    end else begin
                        b -= x * x;
                        if (b < x * x * x) begin
                            lvl = 2;
                        end else begin
                            res.kind = KIND_RANGE;
                            return 1'b1;
                        end
                    end
                end
                cur_level   = lvl[LEVEL_W-1:0];
                cur_offset  = b[WORD_W-1:0];
                walk_active = 1'b1;
                res = read_request(ptr_slots[DIRECT_SLOTS + lvl]);
                return 1'b1;
            end
            OP_RESP: begin
                if (!walk_active)
                    return 1'b0;
                if (cur_level == 0) begin
                    walk_active      = 1'b0;
                    cur_offset       = '0;
                    res.kind         = KIND_MAPPED;
                    res.block_number = it.value;
                    return 1'b1;
                end
                cur_level = cur_level - 1'b1;
                res = read_request(it.value);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Blocks on either side of each mapping region edge for the current block size
    function automatic longint unsigned region_edge(input int k);
        longint unsigned x, s, d, t;
        x = 64'd1 << ptrs_log2();
        s = DIRECT_SLOTS + x;
        d = s + x * x;
        t = d + x * x * x;
        case (k)
            0:       return DIRECT_SLOTS - 1;
            1:       return DIRECT_SLOTS;
            2:       return s - 1;
            3:       return s;
            4:       return d - 1;
            5:       return d;
            6:       return t - 1;
            default: return t;
        endcase
    endfunction

    function automatic logic [31:0] fit32(input longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // Block number spread over direct, single, double, triple and beyond
    function automatic logic [31:0] pick_file_block();
        longint unsigned lo, span, top;
        top  = 64'h1_0000_0000;
        lo   = 0;
        span = 1;
        case ($urandom_range(0, 9))
            0:    return 32'($urandom_range(0, DIRECT_SLOTS - 1));
            1, 2: begin lo = region_edge(1); span = region_edge(3) - lo; end
            3, 4: begin lo = region_edge(3); span = region_edge(5) - lo; end
            5, 6: begin lo = region_edge(5); span = region_edge(7) - lo; end
            7:    return fit32(region_edge($urandom_range(0, 7)));
            8:    return $urandom;
            default: begin
                lo = region_edge(7);
                if (lo >= top)
                    return $urandom;
                span = top - lo;
            end
        endcase
        if (lo + span > top)
            span = top - lo;
        return fit32(lo + ({$urandom, $urandom} % span));
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t make_item(input logic [OP_W-1:0] op,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic [WORD_W-1:0] value,
                                           input logic [WORD_W-1:0] fb);
        in_item_t it;
        it.op         = op;
        it.slot       = slot;
        it.value      = value;
        it.file_block = fb;
        return it;
    endfunction

    // One input transfer, with a random gap in front; valid stays high after
    task automatic send_item(input in_item_t it);
        out_item_t res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (predict_mapping(it, res)) begin
            expected_results.push_back(res);
            handled_items++;
        end else if (it.op == OP_LOAD && it.slot < POINTER_SLOTS) begin
            handled_items++;
        end else begin
            ignored_items++;
        end
    endtask

    task automatic send_response(input logic [WORD_W-1:0] word);
        send_item(make_item(OP_RESP, 4'($urandom), word, $urandom));
    endtask

    task automatic send_map(input logic [WORD_W-1:0] fb);
        send_item(make_item(OP_MAP, 4'($urandom), $urandom, fb));
    endtask

    // Stray or disruptive item: load, stray response, map, unused op
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0:       send_item(make_item(OP_LOAD, 4'($urandom), rand_word(), $urandom));
            1:       send_response(rand_word());
            2:       send_map(pick_file_block());
            default: send_item(make_item(OP_UNUSED, 4'($urandom), $urandom, $urandom));
        endcase
    endtask

    // Map request followed by the responses the walk asks for; a noisy walk may add noise or stop early
    task automatic run_walk(input logic [WORD_W-1:0] fb, input bit noisy);
        int steps;
        steps = 0;
        send_map(fb);
        while (walk_active && steps < 4) begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_noise();
            if (noisy && $urandom_range(0, 39) == 0)
                break;
            send_response(rand_word());
            steps++;
        end
    endtask

    // Finish any open walk so the block ends up idle
    task automatic settle_walk();
        while (walk_active)
            send_response(rand_word());
    endtask

    // Stop sending and wait until every expected result has come back
    task automatic quiesce();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access until pready
    task automatic config_write(input int idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * idx);
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_LOG_BLOCK_SIZE)
            cfg_lbs = val[LBS_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_block_size(input logic [LBS_W-1:0] lbs);
        settle_walk();
        quiesce();
        config_write(REG_LOG_BLOCK_SIZE, {29'd0, lbs});
    endtask

    // Fill every pointer slot, with a zero and an all-ones pointer among them
    task automatic test_pointer_load();
        for (int i = 0; i < POINTER_SLOTS; i++) begin
            case (i)
                0:       send_item(make_item(OP_LOAD, 4'(i), 32'h0, $urandom));
                1:       send_item(make_item(OP_LOAD, 4'(i), 32'hFFFF_FFFF, $urandom));
                2:       send_item(make_item(OP_LOAD, 4'(i), 32'hAAAA_5555, $urandom));
                default: send_item(make_item(OP_LOAD, 4'(i), $urandom, $urandom));
            endcase
        end
        // out-of-range slot and the unused op leave everything alone
        send_item(make_item(OP_LOAD, 4'd15, 32'hDEAD_BEEF, 32'hFFFF_FFFF));
        send_item(make_item(OP_UNUSED, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    // Hand-picked cases at the reset block size
    task automatic test_special_cases();
        send_map(32'd0);                         // zero pointer maps to block zero
        send_map(32'd11);                        // last direct slot
        send_map(32'd12);                        // first single-indirect block
        send_response(32'h0);                    // zero word ends as block zero
        send_map(fit32(region_edge(3)) + 32'd1287);  // double, word indices 5 then 7
        send_response(32'h1234_5678);
        send_response(32'hFFFF_FFFF);
        send_map(fit32(region_edge(5)));         // first triple-indirect block
        send_map(32'd3);                         // ignored while walking
        send_item(make_item(OP_LOAD, 4'd14, 32'h0BAD_F00D, $urandom));  // accepted mid-walk
        send_response(32'h0000_0100);
        send_item(make_item(OP_UNUSED, 4'd0, 32'h0, 32'h0));
        send_response(32'h8000_0001);
        send_response(32'h7FFF_FFFE);
        send_map(fit32(region_edge(7)));         // first block past the triple range
        send_map(32'hFFFF_FFFF);
        send_response(32'h5555_5555);            // stray response while idle
        send_map(fit32(region_edge(5)));         // walk picks up the reloaded slot
        settle_walk();
        quiesce();
    endtask

    // Region edges at every block size setting, extremes first
    task automatic test_block_size_sweep();
        logic [LBS_W-1:0] order [8];
        order = '{3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5};
        foreach (order[i]) begin
            set_block_size(order[i]);
            for (int k = 0; k < 8; k++)
                run_walk(fit32(region_edge(k)), 1'b0);
            run_walk(32'hFFFF_FFFF, 1'b0);
        end
        quiesce();
    endtask

    // Mostly complete walks with random content, some noise and broken walks
    task automatic test_random_traffic(input int target, input int idle_pct,
                                       input int stall_pct);
        int start, next_cfg;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start    = handled_items;
        next_cfg = CFG_EVERY;
        while (handled_items - start < target) begin
            if (handled_items - start >= next_cfg) begin
                set_block_size(3'($urandom_range(0, 7)));
                next_cfg += CFG_EVERY;
            end
            if ($urandom_range(0, 99) < 85)
                run_walk(pick_file_block(), 1'b1);
            else
                send_noise();
        end
        settle_walk();
        quiesce();
    endtask

    // Receiver holds off while the sender keeps going, so the input stalls
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = HOLD_OFF_CYCLES;
        @(posedge aclk);
        for (int i = 0; i < 30; i++) begin
            if (i % 5 == 4)
                run_walk(pick_file_block(), 1'b0);
            else
                send_map(32'($urandom_range(0, DIRECT_SLOTS - 1)));
        end
        settle_walk();
        quiesce();
    endtask

    // Result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none, got kind %0d block %h index %0d",
                         $time, m_data.kind, m_data.block_number, m_data.word_index);
            end else begin
                want = expected_results.pop_front();
                checked++;
                if (want.kind < 3)
                    kind_seen[want.kind]++;
                if (m_data.kind !== want.kind)
                    report_mismatch("kind", 32'(want.kind), 32'(m_data.kind));
                if (m_data.block_number !== want.block_number)
                    report_mismatch("block_number", want.block_number, m_data.block_number);
                if (m_data.word_index !== want.word_index)
                    report_mismatch("word_index", 32'(want.word_index),
                                    32'(m_data.word_index));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, expected_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_pointer_load();
        test_special_cases();
        test_block_size_sweep();
        test_random_traffic(300, 0, 0);
        test_random_traffic(300, 72, 0);
        test_random_traffic(300, 0, 72);
        test_random_traffic(300, 27, 27);
        test_output_backpressure();
        quiesce();

        if (expected_results.size() != 0) begin
            fail_count++;
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
        end
        $display("Covered %0d effective and %0d ignored items; %0d results checked",
                 handled_items, ignored_items, checked);
        $display("  (%0d reads, %0d mappings, %0d out of range) over all block sizes",
                 kind_seen[0], kind_seen[1], kind_seen[2]);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
